FILE: design/ipsd_pkg.sv
// ----------------------------------------------------------------------------
// ipsd_pkg
// Shared types and constants of the isochronous packet size distributor.
// ----------------------------------------------------------------------------
package ipsd_pkg;

    localparam int MAX_PACKETS       = 32;
    localparam int PRIMING_TRANSFERS = 4;
    localparam int COUNT_CAP         = 1000;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT  = 3'd0,
        CFG_BYTES_PER_SMP  = 3'd1,
        CFG_PACKETS        = 3'd2,
        CFG_NOMINAL_FRAMES = 3'd3
    } cfg_index_t;

    // payload widths
    localparam int LEN_W = 16;

    // datapath widths
    localparam int FRAME_W = 7;   // channel_count * bytes_per_sample
    localparam int NPK_W   = 6;   // packet count 1..MAX_PACKETS
    localparam int NF_W    = 12;  // packets * frame
    localparam int NOM_W   = 22;  // nominal transfer length
    localparam int REM_W   = 18;  // carried remainder, signed
    localparam int TOT_W   = 24;  // total, signed
    localparam int NXT_W   = 25;  // running offset / packet sizes, signed
    localparam int ACC_W   = 30;  // scaled compare terms, signed
    localparam int CNT_W   = 10;  // transfers issued

    localparam logic signed [REM_W-1:0] REM_MAX = 18'sd131071;
    localparam logic signed [REM_W-1:0] REM_MIN = -18'sd131072;

    // divider
    localparam int DIV_DW = 23;
    localparam int DIV_VW = 7;
    localparam int DIV_CW = 5;

    // shared multiplier
    localparam int MUL_AW = 25;
    localparam int MUL_BW = 13;
    localparam int MUL_PW = MUL_AW + MUL_BW + 1;

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_MUL_FRAME = 11'b000_0000_0010,
        ST_MUL_NF    = 11'b000_0000_0100,
        ST_MUL_NOM   = 11'b000_0000_1000,
        ST_TOTAL     = 11'b000_0001_0000,
        ST_DIV1      = 11'b000_0010_0000,
        ST_DIV2      = 11'b000_0100_0000,
        ST_MUL_SMALL = 11'b000_1000_0000,
        ST_MUL_NS    = 11'b001_0000_0000,
        ST_EMIT      = 11'b010_0000_0000,
        ST_ZERO      = 11'b100_0000_0000
    } state_t;

endpackage

FILE: design/ipsd_cfg_if.sv
// ----------------------------------------------------------------------------
// ipsd_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface ipsd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ipsd_pkg::CFG_IDX_W-1:0]  index;
    logic [ipsd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/ipsd_req_if.sv
// ----------------------------------------------------------------------------
// ipsd_req_if
// Input channel: one word per playback transfer.
// ----------------------------------------------------------------------------
interface ipsd_req_if;
    logic                         valid;
    logic                         ready;
    logic [ipsd_pkg::LEN_W-1:0]  captured_length;

    modport source (output valid, output captured_length, input ready);
    modport sink   (input valid, input captured_length, output ready);
endinterface

FILE: design/ipsd_rsp_if.sv
// ----------------------------------------------------------------------------
// ipsd_rsp_if
// Result channel: one word per isochronous packet.
// ----------------------------------------------------------------------------
interface ipsd_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ipsd_pkg::LEN_W-1:0]  packet_offset;
    logic [ipsd_pkg::LEN_W-1:0]  packet_length;
    logic [ipsd_pkg::LEN_W-1:0]  transfer_length;
    logic                         fill_silence;
    logic                         last_packet;

    modport source (output valid, output packet_offset, output packet_length,
                    output transfer_length, output fill_silence,
                    output last_packet, input ready);
    modport sink   (input valid, input packet_offset, input packet_length,
                    input transfer_length, input fill_silence,
                    input last_packet, output ready);
endinterface

FILE: design/ipsd_div.sv
// ----------------------------------------------------------------------------
// ipsd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ipsd_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ipsd_pkg::DIV_DW-1:0]   dividend,
    input  logic [ipsd_pkg::DIV_VW-1:0]   divisor,
    output logic                           done,
    output logic [ipsd_pkg::DIV_DW-1:0]   quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [ipsd_pkg::DIV_CW-1:0]  cnt_reg, cnt_next;
    logic [ipsd_pkg::DIV_VW-1:0]  rem_reg, rem_next;
    logic [ipsd_pkg::DIV_DW-1:0]  quo_reg, quo_next;
    logic [ipsd_pkg::DIV_VW-1:0]  dsr_reg, dsr_next;
    logic [ipsd_pkg::DIV_VW:0]    trial;
    logic [ipsd_pkg::DIV_VW:0]    trial_sub;

    assign trial     = {rem_reg, quo_reg[ipsd_pkg::DIV_DW-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial_sub[ipsd_pkg::DIV_VW-1:0];
                quo_next = {quo_reg[ipsd_pkg::DIV_DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[ipsd_pkg::DIV_VW-1:0];
                quo_next = {quo_reg[ipsd_pkg::DIV_DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = ipsd_pkg::DIV_CW'(ipsd_pkg::DIV_DW - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: design/iso_packet_size_distributor.sv
// ----------------------------------------------------------------------------
// iso_packet_size_distributor
// Splits each playback transfer into frame-aligned isochronous packets.
// ----------------------------------------------------------------------------
// Usage:
//   cfg : register writes (channel count, bytes per sample, packets per
//         transfer, nominal frames per packet); always ready, write only
//         while the block is idle.
//   req : one word per playback transfer carrying the last captured length.
//   rsp : one word per packet (offset, length, silence flag); the last word
//         of a transfer carries transfer_length and last_packet.
// Timing: after the accepting edge a transfer runs the setup states
//   MUL_FRAME, MUL_NF, MUL_NOM and TOTAL, two passes of the divider and the
//   multiply states MUL_SMALL and MUL_NS, then issues its packets in turn;
//   a zero frame size skips the second divide. req is ready only when the
//   sequencer is idle. A zero byte count yields a single word.
// A stalled rsp holds the output register and freezes packet issue.
// Reset restores register defaults, clears the carried remainder and the
//   transfer count, so the next transfers are primed with silence.
// ----------------------------------------------------------------------------
module iso_packet_size_distributor (
    input  logic       clk,
    input  logic       rst_n,
    ipsd_cfg_if.sink   cfg,
    ipsd_req_if.sink   req,
    ipsd_rsp_if.source rsp
);

    // configuration registers
    logic [3:0]  cc_reg;
    logic [2:0]  bps_reg;
    logic [5:0]  ppt_reg;
    logic [9:0]  nom_reg;

    // carried state
    logic signed [ipsd_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [ipsd_pkg::CNT_W-1:0]        issued_reg, issued_next;

    ipsd_pkg::state_t state_reg, state_next;

    // working registers
    logic [ipsd_pkg::LEN_W-1:0]          cap_reg, cap_next;
    logic [ipsd_pkg::FRAME_W-1:0]        frame_reg, frame_next;
    logic [ipsd_pkg::NPK_W-1:0]          n_reg, n_next;
    logic [ipsd_pkg::NF_W-1:0]           nf_reg, nf_next;
    logic [ipsd_pkg::NOM_W-1:0]          nominal_reg, nominal_next;
    logic signed [ipsd_pkg::TOT_W-1:0]   total_reg, total_next;
    logic                                neg_reg, neg_next;
    logic                                silence_reg, silence_next;
    logic [ipsd_pkg::DIV_DW-1:0]         q2_reg, q2_next;
    logic signed [ipsd_pkg::NXT_W-1:0]   small_reg, small_next;
    logic signed [ipsd_pkg::NXT_W-1:0]   large_reg, large_next;
    logic signed [ipsd_pkg::ACC_W-1:0]   ns_reg, ns_next;
    logic signed [ipsd_pkg::ACC_W-1:0]   nl_reg, nl_next;
    logic signed [ipsd_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ipsd_pkg::ACC_W-1:0]   nnext_reg, nnext_next;
    logic signed [ipsd_pkg::NXT_W-1:0]   next_reg, next_next;
    logic [ipsd_pkg::NPK_W-1:0]          k_reg, k_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [ipsd_pkg::LEN_W-1:0]  out_off_reg, out_off_next;
    logic [ipsd_pkg::LEN_W-1:0]  out_len_reg, out_len_next;
    logic [ipsd_pkg::LEN_W-1:0]  out_tot_reg, out_tot_next;
    logic                        out_sil_reg, out_sil_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_free;

    // shared multiplier
    logic signed [ipsd_pkg::MUL_AW-1:0] mul_a;
    logic [ipsd_pkg::MUL_BW-1:0]        mul_b;
    logic signed [ipsd_pkg::MUL_PW-1:0] mul_p;

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    // divider
    logic                         div_start;
    logic                         div_done;
    logic [ipsd_pkg::DIV_DW-1:0]  div_dividend;
    logic [ipsd_pkg::DIV_VW-1:0]  div_divisor;
    logic [ipsd_pkg::DIV_DW-1:0]  div_quotient;

    ipsd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // transfer total selection
    logic                                priming;
    logic [ipsd_pkg::NOM_W-1:0]          chosen;
    logic signed [ipsd_pkg::TOT_W-1:0]   total_sum;
    logic signed [ipsd_pkg::TOT_W-1:0]   total_mag;

    assign priming   = issued_reg <= ipsd_pkg::CNT_W'(ipsd_pkg::PRIMING_TRANSFERS);
    assign chosen    = priming ? nominal_reg : ipsd_pkg::NOM_W'(cap_reg);
    assign total_sum = $signed({2'b00, chosen}) + ipsd_pkg::TOT_W'(rem_reg);
    assign total_mag = total_sum[ipsd_pkg::TOT_W-1] ? -total_sum : total_sum;

    // packet decision
    logic                                take_large;
    logic signed [ipsd_pkg::NXT_W-1:0]   step;
    logic signed [ipsd_pkg::NXT_W-1:0]   next_new;
    logic signed [ipsd_pkg::NXT_W:0]     rem_diff;
    logic signed [ipsd_pkg::REM_W-1:0]   rem_sat;
    logic                                last_k;

    assign take_large = acc_reg > (nnext_reg + nl_reg);
    assign step       = take_large ? large_reg : small_reg;
    assign next_new   = next_reg + step;
    assign rem_diff   = (ipsd_pkg::NXT_W+1)'(total_reg) - (ipsd_pkg::NXT_W+1)'(next_new);
    assign last_k     = k_reg == (n_reg - 1'b1);

    always_comb
    begin
        if (rem_diff > (ipsd_pkg::NXT_W+1)'(ipsd_pkg::REM_MAX))
            rem_sat = ipsd_pkg::REM_MAX;
        else if (rem_diff < (ipsd_pkg::NXT_W+1)'(ipsd_pkg::REM_MIN))
            rem_sat = ipsd_pkg::REM_MIN;
        else
            rem_sat = rem_diff[ipsd_pkg::REM_W-1:0];
    end

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = state_reg == ipsd_pkg::ST_IDLE;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        issued_next    = issued_reg;
        cap_next       = cap_reg;
        frame_next     = frame_reg;
        n_next         = n_reg;
        nf_next        = nf_reg;
        nominal_next   = nominal_reg;
        total_next     = total_reg;
        neg_next       = neg_reg;
        silence_next   = silence_reg;
        q2_next        = q2_reg;
        small_next     = small_reg;
        large_next     = large_reg;
        ns_next        = ns_reg;
        nl_next        = nl_reg;
        acc_next       = acc_reg;
        nnext_next     = nnext_reg;
        next_next      = next_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_off_next   = out_off_reg;
        out_len_next   = out_len_reg;
        out_tot_next   = out_tot_reg;
        out_sil_next   = out_sil_reg;
        out_last_next  = out_last_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;

        case (state_reg)
            ipsd_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    cap_next   = req.captured_length;
                    state_next = ipsd_pkg::ST_MUL_FRAME;
                end
            end
            ipsd_pkg::ST_MUL_FRAME:
            begin
                mul_a      = ipsd_pkg::MUL_AW'(cc_reg);
                mul_b      = ipsd_pkg::MUL_BW'(bps_reg);
                frame_next = mul_p[ipsd_pkg::FRAME_W-1:0];
                if (ppt_reg == '0)
                    n_next = ipsd_pkg::NPK_W'(1);
                else if (ppt_reg > ipsd_pkg::NPK_W'(ipsd_pkg::MAX_PACKETS))
                    n_next = ipsd_pkg::NPK_W'(ipsd_pkg::MAX_PACKETS);
                else
                    n_next = ppt_reg;
                state_next = ipsd_pkg::ST_MUL_NF;
            end
            ipsd_pkg::ST_MUL_NF:
            begin
                mul_a      = ipsd_pkg::MUL_AW'(frame_reg);
                mul_b      = ipsd_pkg::MUL_BW'(n_reg);
                nf_next    = mul_p[ipsd_pkg::NF_W-1:0];
                state_next = ipsd_pkg::ST_MUL_NOM;
            end
            ipsd_pkg::ST_MUL_NOM:
            begin
                mul_a        = ipsd_pkg::MUL_AW'(nom_reg);
                mul_b        = ipsd_pkg::MUL_BW'(nf_reg);
                nominal_next = mul_p[ipsd_pkg::NOM_W-1:0];
                state_next   = ipsd_pkg::ST_TOTAL;
            end
            ipsd_pkg::ST_TOTAL:
            begin
                if (issued_reg < ipsd_pkg::CNT_W'(ipsd_pkg::COUNT_CAP))
                    issued_next = issued_reg + 1'b1;
                silence_next = issued_next <= ipsd_pkg::CNT_W'(ipsd_pkg::PRIMING_TRANSFERS);
                if (chosen == '0)
                begin
                    state_next = ipsd_pkg::ST_ZERO;
                end
                else
                begin
                    total_next   = total_sum;
                    neg_next     = total_sum[ipsd_pkg::TOT_W-1];
                    div_start    = 1'b1;
                    div_dividend = total_mag[ipsd_pkg::DIV_DW-1:0];
                    div_divisor  = ipsd_pkg::DIV_VW'(n_reg);
                    state_next   = ipsd_pkg::ST_DIV1;
                end
            end
            ipsd_pkg::ST_DIV1:
            begin
                if (div_done)
                begin
                    if (frame_reg == '0)
                    begin
                        q2_next    = '0;
                        state_next = ipsd_pkg::ST_MUL_SMALL;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = div_quotient;
                        div_divisor  = frame_reg;
                        state_next   = ipsd_pkg::ST_DIV2;
                    end
                end
            end
            ipsd_pkg::ST_DIV2:
            begin
                if (div_done)
                begin
                    q2_next    = div_quotient;
                    state_next = ipsd_pkg::ST_MUL_SMALL;
                end
            end
            ipsd_pkg::ST_MUL_SMALL:
            begin
                mul_a = ipsd_pkg::MUL_AW'(q2_reg);
                mul_b = ipsd_pkg::MUL_BW'(frame_reg);
                if (neg_reg)
                    small_next = -mul_p[ipsd_pkg::NXT_W-1:0];
                else
                    small_next = mul_p[ipsd_pkg::NXT_W-1:0];
                large_next = small_next + ipsd_pkg::NXT_W'(frame_reg);
                state_next = ipsd_pkg::ST_MUL_NS;
            end
            ipsd_pkg::ST_MUL_NS:
            begin
                // n*small and n*large = n*small + n*frame
                mul_a      = small_reg;
                mul_b      = ipsd_pkg::MUL_BW'(n_reg);
                ns_next    = mul_p[ipsd_pkg::ACC_W-1:0];
                nl_next    = ns_next + ipsd_pkg::ACC_W'(nf_reg);
                acc_next   = ipsd_pkg::ACC_W'(total_reg);
                nnext_next = '0;
                next_next  = '0;
                k_next     = '0;
                state_next = ipsd_pkg::ST_EMIT;
            end
            ipsd_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_off_next   = next_reg[ipsd_pkg::LEN_W-1:0];
                    out_len_next   = step[ipsd_pkg::LEN_W-1:0];
                    out_tot_next   = last_k ? next_new[ipsd_pkg::LEN_W-1:0] : '0;
                    out_sil_next   = silence_reg;
                    out_last_next  = last_k;
                    // running target (k+1)*total and n*next
                    acc_next       = acc_reg + ipsd_pkg::ACC_W'(total_reg);
                    nnext_next     = nnext_reg + (take_large ? nl_reg : ns_reg);
                    next_next      = next_new;
                    k_next         = k_reg + 1'b1;
                    if (last_k)
                    begin
                        rem_next   = rem_sat;
                        state_next = ipsd_pkg::ST_IDLE;
                    end
                end
            end
            ipsd_pkg::ST_ZERO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_off_next   = '0;
                    out_len_next   = nominal_reg[ipsd_pkg::LEN_W-1:0];
                    out_tot_next   = nominal_reg[ipsd_pkg::LEN_W-1:0];
                    out_sil_next   = 1'b1;
                    out_last_next  = 1'b1;
                    state_next     = ipsd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ipsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg        <= 4'd2;
            bps_reg       <= 3'd4;
            ppt_reg       <= 6'd8;
            nom_reg       <= 10'd6;
            rem_reg       <= '0;
            issued_reg    <= '0;
            state_reg     <= ipsd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    ipsd_pkg::CFG_CHANNEL_COUNT:  cc_reg  <= cfg.data[3:0];
                    ipsd_pkg::CFG_BYTES_PER_SMP:  bps_reg <= cfg.data[2:0];
                    ipsd_pkg::CFG_PACKETS:        ppt_reg <= cfg.data[5:0];
                    ipsd_pkg::CFG_NOMINAL_FRAMES: nom_reg <= cfg.data[9:0];
                    default:
                    begin
                    end
                endcase
            end
            rem_reg       <= rem_next;
            issued_reg    <= issued_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_reg      <= cap_next;
        frame_reg    <= frame_next;
        n_reg        <= n_next;
        nf_reg       <= nf_next;
        nominal_reg  <= nominal_next;
        total_reg    <= total_next;
        neg_reg      <= neg_next;
        silence_reg  <= silence_next;
        q2_reg       <= q2_next;
        small_reg    <= small_next;
        large_reg    <= large_next;
        ns_reg       <= ns_next;
        nl_reg       <= nl_next;
        acc_reg      <= acc_next;
        nnext_reg    <= nnext_next;
        next_reg     <= next_next;
        k_reg        <= k_next;
        out_off_reg  <= out_off_next;
        out_len_reg  <= out_len_next;
        out_tot_reg  <= out_tot_next;
        out_sil_reg  <= out_sil_next;
        out_last_reg <= out_last_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.packet_offset   = out_off_reg;
    assign rsp.packet_length   = out_len_reg;
    assign rsp.transfer_length = out_tot_reg;
    assign rsp.fill_silence    = out_sil_reg;
    assign rsp.last_packet     = out_last_reg;

endmodule
